[rtl/core/wdt_pkg.sv]
`default_nettype none
package wdt_pkg;

  // function codes of an input request
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_FEED = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MODE   = 2'd1;
  localparam logic [1:0] CFG_RELOAD = 2'd2;

  // feed sequence bytes and reload floor
  localparam logic [7:0]  FEED_FIRST   = 8'hAA;
  localparam logic [7:0]  FEED_SECOND  = 8'h55;
  localparam logic [31:0] RELOAD_FLOOR = 32'h0000_00FF;
  localparam logic [31:0] COUNT_RESET  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] feed_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count_now;
    logic        is_running;
    logic        timeout_seen;
    logic        interrupt_request;
    logic        reset_request;
  } out_item_t;

  // configuration as seen by the counter core
  typedef struct packed {
    logic        enable;
    logic        reset_mode;
    logic [31:0] reload;  // already raised to the floor
    logic        stop;    // high while enable is being written to 0
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/watchdog_timer_with_feed_sequence.sv]
// Channel   Direction  Handshake                Payload
// in        request    in_valid / in_ready      in_data  (func, feed_byte)
// out       result     out_valid / out_ready    out_data (count, flags, requests)
// cfg       write      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request per cycle unless the output stalls; its result appears in the
// output register in the cycle after acceptance. The state update and result
// are one pass of logic from the counter registers into the output register.
// Reset (rst, synchronous) clears counting, arming and timeout, sets the
// counter to all ones and the reload register to 255.
// A stalled output holds its result; in_ready stays high while it is drained.
`default_nettype none
module watchdog_timer_with_feed_sequence (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wdt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wdt_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  wdt_pkg::cfg_t cfg;

  wdt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wdt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/core/wdt_cfg.sv]
`default_nettype none
module wdt_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output wdt_pkg::cfg_t    cfg
);

  logic        enable;
  logic        reset_mode;
  logic [31:0] reload;
  logic        stop;
  logic        wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // counting stops at the same edge that writes enable to 0
  assign stop = wr && (cfg_index == wdt_pkg::CFG_ENABLE) && !cfg_data[0];

  // register file; reload is clamped at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      reset_mode <= 1'b0;
      reload     <= wdt_pkg::RELOAD_FLOOR;
    end else begin
      if (wr) begin
        case (cfg_index)
          wdt_pkg::CFG_ENABLE: begin
            enable <= cfg_data[0];
          end
          wdt_pkg::CFG_MODE: begin
            reset_mode <= cfg_data[0];
          end
          wdt_pkg::CFG_RELOAD: begin
            reload <= (cfg_data < wdt_pkg::RELOAD_FLOOR) ? wdt_pkg::RELOAD_FLOOR : cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg.enable     = enable;
  assign cfg.reset_mode = reset_mode;
  assign cfg.reload     = reload;
  assign cfg.stop       = stop;

endmodule
`default_nettype wire

[rtl/core/wdt_core.sv]
`default_nettype none
module wdt_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wdt_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wdt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wdt_pkg::out_item_t     out_data
);

  logic [31:0] down_counter, down_counter_next;
  logic        counting, counting_next;
  logic        feed_armed, feed_armed_next;
  logic        timeout_flag, timeout_flag_next;
  logic        irq, rreq;
  logic        accept;

  // result register frees up when empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // next state for one request
  always_comb begin
    down_counter_next = down_counter;
    counting_next     = counting;
    feed_armed_next   = feed_armed;
    timeout_flag_next = timeout_flag;
    irq               = 1'b0;
    rreq              = 1'b0;
    case (in_data.func)
      wdt_pkg::FUNC_TICK: begin
        if (counting) begin
          if (down_counter == '0) begin
            timeout_flag_next = 1'b1;
            rreq              = cfg.reset_mode;
            irq               = !cfg.reset_mode;
            down_counter_next = cfg.reload;
          end else begin
            down_counter_next = down_counter - 32'd1;
          end
        end
      end
      wdt_pkg::FUNC_FEED: begin
        if (in_data.feed_byte == wdt_pkg::FEED_FIRST) begin
          feed_armed_next = 1'b1;
        end else if (in_data.feed_byte == wdt_pkg::FEED_SECOND && feed_armed) begin
          feed_armed_next   = 1'b0;
          down_counter_next = cfg.reload;
          if (cfg.enable) begin
            counting_next = 1'b1;
          end
        end else begin
          feed_armed_next = 1'b0;
        end
      end
      default: begin
        // status read and unused code leave state alone
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      down_counter <= wdt_pkg::COUNT_RESET;
      counting     <= 1'b0;
      feed_armed   <= 1'b0;
      timeout_flag <= 1'b0;
    end else if (accept) begin
      down_counter <= down_counter_next;
      counting     <= counting_next && !cfg.stop;
      feed_armed   <= feed_armed_next;
      timeout_flag <= timeout_flag_next;
    end else if (cfg.stop) begin
      counting <= 1'b0;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.count_now         <= down_counter_next;
      out_data.is_running        <= counting_next;
      out_data.timeout_seen      <= timeout_flag_next;
      out_data.interrupt_request <= irq;
      out_data.reset_request     <= rreq;
    end
  end

endmodule
`default_nettype wire

[rtl/core/wdt_checker.sv]
`default_nettype none
module wdt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire wdt_pkg::out_item_t out_data
);

  // an underflow raises exactly one kind of request
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.interrupt_request && out_data.reset_request))
    else $error("interrupt and reset request together");

  // any request implies the sticky timeout flag and continued counting
  a_req_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.interrupt_request || out_data.reset_request)
    |-> out_data.timeout_seen && out_data.is_running)
    else $error("request without timeout flag or running counter");

  // an accepted request shows a result in the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind watchdog_timer_with_feed_sequence wdt_checker u_wdt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/tb_watchdog_timer_with_feed_sequence.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_watchdog_timer_with_feed_sequence;

  // codes the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 80;

  // model of the watchdog plus the queue of results still owed
  class watchdog_scoreboard;
    bit                 enable_bit;
    bit                 reset_mode;
    logic [31:0]        reload_reg;
    logic [31:0]        counter;
    bit                 running;
    bit                 armed;
    bit                 tripped;
    wdt_pkg::out_item_t owed_q[$];
    int unsigned        mismatches;
    int unsigned        requests;
    int unsigned        checked;
    int unsigned        interrupts;
    int unsigned        resets;

    function void clear_state();
      enable_bit = 1'b0;
      reset_mode = 1'b0;
      reload_reg = 32'd255;
      counter    = wdt_pkg::COUNT_RESET;
      running    = 1'b0;
      armed      = 1'b0;
      tripped    = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        wdt_pkg::CFG_ENABLE: begin
          enable_bit = data[0];
          if (!data[0]) running = 1'b0;
        end
        wdt_pkg::CFG_MODE:   reset_mode = data[0];
        wdt_pkg::CFG_RELOAD: reload_reg = data;
        default: ;
      endcase
    endfunction

    // advance the model by one accepted request and queue its result
    function void note_request(wdt_pkg::in_item_t req);
      wdt_pkg::out_item_t want;
      logic [31:0]        load_val;
      want = '0;
      load_val = (reload_reg < wdt_pkg::RELOAD_FLOOR) ? wdt_pkg::RELOAD_FLOOR : reload_reg;
      if (req.func == wdt_pkg::FUNC_TICK) begin
        if (running) begin
          if (counter == 32'd0) begin
            tripped = 1'b1;
            if (reset_mode) begin
              want.reset_request = 1'b1;
              resets++;
            end else begin
              want.interrupt_request = 1'b1;
              interrupts++;
            end
            counter = load_val;
          end else begin
            counter = counter - 32'd1;
          end
        end
      end else if (req.func == wdt_pkg::FUNC_FEED) begin
        if (req.feed_byte == wdt_pkg::FEED_FIRST) begin
          armed = 1'b1;
        end else if (req.feed_byte == wdt_pkg::FEED_SECOND && armed) begin
          armed = 1'b0;
          counter = load_val;
          if (enable_bit) running = 1'b1;
        end else begin
          armed = 1'b0;
        end
      end
      // tick while stopped, status read and the spare code change nothing
      want.count_now    = counter;
      want.is_running   = running;
      want.timeout_seen = tripped;
      owed_q.push_back(want);
      requests++;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    endfunction

    function void check_result(wdt_pkg::out_item_t got);
      wdt_pkg::out_item_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %h arrived with nothing owed", got);
      end else begin
        want = owed_q.pop_front();
        checked++;
        compare("count_now", want.count_now, got.count_now);
        compare("is_running", 32'(want.is_running), 32'(got.is_running));
        compare("timeout_seen", 32'(want.timeout_seen), 32'(got.timeout_seen));
        compare("interrupt_request", 32'(want.interrupt_request),
                32'(got.interrupt_request));
        compare("reset_request", 32'(want.reset_request), 32'(got.reset_request));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  wdt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  wdt_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  watchdog_scoreboard sb;
  bit          calm = 1'b0;
  bit          hold_pending = 1'b0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  watchdog_timer_with_feed_sequence u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // check every result taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // offer one request; returns at the falling edge after it is taken, valid still high
  task automatic send_request(logic [1:0] func, logic [7:0] feed_byte);
    wdt_pkg::in_item_t req;
    req.func = func;
    req.feed_byte = feed_byte;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering and wait until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // upper bits of the one-bit registers carry noise
  task automatic configure(bit en, bit mode, logic [31:0] reload);
    logic [31:0] word;
    drain_results();
    word = $urandom();
    word[0] = en;
    write_reg(wdt_pkg::CFG_ENABLE, word);
    word = $urandom();
    word[0] = mode;
    write_reg(wdt_pkg::CFG_MODE, word);
    write_reg(wdt_pkg::CFG_RELOAD, reload);
  endtask

  // a feed sequence, then mostly ticks with reads, stray bytes, broken feeds and further feeds
  task automatic run_phase(int count, int feed_odds);
    int sent;
    int r;
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
    sent = 2;
    while (sent < count) begin
      r = $urandom_range(0, 999);
      if (r < feed_odds) begin
        send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
        send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
        sent += 2;
      end else if (r < feed_odds + 25) begin
        send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
        send_request(wdt_pkg::FUNC_FEED, 8'($urandom()));
        sent += 2;
      end else if (r < feed_odds + 65) begin
        send_request(wdt_pkg::FUNC_FEED, 8'($urandom()));
        sent++;
      end else if (r < feed_odds + 125) begin
        send_request($urandom_range(0, 1) ? wdt_pkg::FUNC_READ : FUNC_SPARE,
                     8'($urandom()));
        sent++;
      end else begin
        send_request(wdt_pkg::FUNC_TICK, 8'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sb = new;
    sb.clear_state();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reads, spare code, tick while stopped, feed while disabled
    send_request(wdt_pkg::FUNC_READ, 8'hFF);
    send_request(FUNC_SPARE, 8'h00);
    send_request(wdt_pkg::FUNC_TICK, 8'hFF);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
    send_request(wdt_pkg::FUNC_TICK, 8'h00);

    // lone second byte, repeated first byte, feed while running, stray bytes
    configure(1'b1, 1'b0, 32'd0);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
    send_request(wdt_pkg::FUNC_TICK, 8'h00);
    send_request(wdt_pkg::FUNC_TICK, 8'hFF);
    send_request(wdt_pkg::FUNC_TICK, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, 8'h00);
    send_request(wdt_pkg::FUNC_FEED, 8'hFF);
    send_request(wdt_pkg::FUNC_READ, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_FIRST);
    send_request(wdt_pkg::FUNC_FEED, wdt_pkg::FEED_SECOND);
    send_request(wdt_pkg::FUNC_TICK, 8'h00);

    // disable stops the countdown, counter holds
    configure(1'b0, 1'b0, 32'd0);
    send_request(wdt_pkg::FUNC_TICK, 8'h00);
    send_request(wdt_pkg::FUNC_READ, 8'h00);

    // random phases; the long ones run past an underflow
    configure(1'b1, 1'b0, 32'd0);
    run_phase(340, 0);
    configure(1'b1, 1'b1, 32'h0000_0100);
    hold_pending = 1'b1;
    run_phase(340, 0);
    configure(1'b1, 1'b0, 32'hFFFF_FFFF);
    run_phase(40, 40);
    configure(1'b0, 1'b1, $urandom());
    run_phase(40, 40);
    configure(1'b1, 1'b1, 32'h0000_00FE);
    run_phase(340, 1);
    configure(1'b1, 1'($urandom_range(0, 1)), $urandom_range(255, 300));
    run_phase(25, 20);
    configure(1'b1, 1'b0, wdt_pkg::RELOAD_FLOOR);
    write_reg(CFG_UNUSED, $urandom());
    run_phase(25, 20);
    calm = 1'b1;
    configure(1'b1, 1'($urandom_range(0, 1)), $urandom());
    run_phase(25, 20);

    drain_results();
    repeat (4) @(negedge clk);

    $display("covered %0d requests, %0d results checked, %0d register writes",
             sb.requests, sb.checked, cfg_writes);
    $display("underflows: %0d interrupt, %0d reset; %0d mismatches",
             sb.interrupts, sb.resets, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
